/* sv/piecewise_linear_table_interp_macros.svh */
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLTI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plti port check failed");

// Next-cycle implication, checked outside reset.
`define PLTI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plti port check failed");

`endif

/* sv/plti_pkg.sv */
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator package
// Types, codes and the power-up breakpoint table shared by the RTL files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
    localparam int ALU_W      = 34;
    localparam int MAG_W      = 33;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EQUAL = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              operation;
        logic [3:0]        point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } t_alu_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_LEFT0,
        S_SCAN,
        S_CLL,
        S_CLR,
        S_DX,
        S_DY,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_ADD,
        S_DONE
    } t_state;

    // Power-up contents: Mach number in x, maximum deflection in radians in y,
    // both Q16.16 rounded to nearest. The last entry powers up as zero.
    function automatic t_entry reset_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        case (idx)
            4'd0:    e = '{x: 32'sd68813,  y: 32'sd638};
            4'd1:    e = '{x: 32'sd72090,  y: 32'sd1733};
            4'd2:    e = '{x: 32'sd78643,  y: 32'sd4511};
            4'd3:    e = '{x: 32'sd85197,  y: 32'sd7620};
            4'd4:    e = '{x: 32'sd91750,  y: 32'sd10783};
            4'd5:    e = '{x: 32'sd104858, y: 32'sd16759};
            4'd6:    e = '{x: 32'sd117965, y: 32'sd21942};
            4'd7:    e = '{x: 32'sd131072, y: 32'sd26278};
            4'd8:    e = '{x: 32'sd163840, y: 32'sd34083};
            4'd9:    e = '{x: 32'sd196608, y: 32'sd38974};
            4'd10:   e = '{x: 32'sd262144, y: 32'sd44350};
            4'd11:   e = '{x: 32'sd327680, y: 32'sd47031};
            4'd12:   e = '{x: 32'sd393216, y: 32'sd48543};
            4'd13:   e = '{x: 32'sd524288, y: 32'sd50089};
            4'd14:   e = '{x: 32'sd655360, y: 32'sd50819};
            default: e = '{x: 32'sd0,      y: 32'sd0};
        endcase
        return e;
    endfunction

    function automatic logic [ALU_W-1:0] sext(input logic [31:0] v);
        return {{(ALU_W - 32){v[31]}}, v};
    endfunction

    // Magnitude of a two's complement ALU result; fits one bit less.
    function automatic logic [MAG_W-1:0] mag(input logic [ALU_W-1:0] v);
        logic [ALU_W-1:0] t;
        t = v[ALU_W-1] ? (~v + ALU_W'(1)) : v;
        return t[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/piecewise_linear_table_interp.sv */
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator
// Interpolates a signed Q16.16 ordinate from a writable breakpoint table.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                         Payload
//  input     in         i_in_valid / o_in_stall           i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_stall         o_out_data (t_out_item)
//  config    in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
//  A write item updates one table entry in the cycle it is accepted and the
//  block is ready again in the next cycle. A query takes one table read per
//  breakpoint searched, then 33 shift-add steps of the multiply and 32
//  compare-subtract steps of the divide, all on the single shared 34-bit
//  adder. Equal breakpoints or an early overflow finish sooner. Reset is
//  synchronous; the table comes up with its power-up contents at once,
//  with no clearing pass. A finished result waits in the output register
//  while the next item is taken in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Input items
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  plti_pkg::t_in_item   i_in_data,
    // Result items
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output plti_pkg::t_out_item  o_out_data
);
    import plti_pkg::*;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_EXTRAP      = 1'b1;

    // Configuration registers.
    logic [COUNT_W-1:0] r_point_count;
    logic               r_extrap;

    // Sequencer state and datapath registers.
    t_state             r_state,     n_state;
    logic signed [31:0] r_x,         n_x;
    logic [IDX_W-1:0]   r_i,         n_i;
    t_entry             r_left,      n_left;
    t_entry             r_right,     n_right;
    logic               r_lt,        n_lt;
    logic [MAG_W-1:0]   r_dq_mag,    n_dq_mag;
    logic               r_dq_neg,    n_dq_neg;
    logic [MAG_W-1:0]   r_dx_mag,    n_dx_mag;
    logic               r_neg,       n_neg;
    logic [MAG_W-1:0]   r_mcand,     n_mcand;
    logic [MAG_W-1:0]   r_acc,       n_acc;
    logic [MAG_W-1:0]   r_lo,        n_lo;
    logic [5:0]         r_cnt,       n_cnt;
    logic signed [31:0] r_res,       n_res;
    logic [1:0]         r_status,    n_status;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data,  n_out_data;

    t_tbl_wr            tbl_wr;
    logic [IDX_W-1:0]   rd_idx;
    t_entry             rd_entry;
    t_alu_req           alu_req;
    t_alu_res           alu_res;

    logic [COUNT_W-1:0] n_used;
    logic [IDX_W-1:0]   last;
    logic               gt;
    logic signed [31:0] yr_clamp;
    logic [MAG_W-1:0]   trial;

    plti_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry)
    );

    plti_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle; the
    // register is chosen by the word address bit.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= COUNT_W'(15);
            r_extrap      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_POINT_COUNT: r_point_count <= pwdata[COUNT_W-1:0];
                REG_EXTRAP:      r_extrap      <= pwdata[0];
                default:         r_extrap      <= r_extrap;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POINT_COUNT: prdata = {{(32 - COUNT_W){1'b0}}, r_point_count};
            REG_EXTRAP:      prdata = {31'b0, r_extrap};
            default:         prdata = '0;
        endcase
    end

    // The breakpoint count in use is held between two and the table depth;
    // the search never goes past the last interval.
    always_comb begin
        if (r_point_count < COUNT_W'(2)) begin
            n_used = COUNT_W'(2);
        end else if (r_point_count > COUNT_W'(MAX_POINTS)) begin
            n_used = COUNT_W'(MAX_POINTS);
        end else begin
            n_used = r_point_count;
        end
    end

    assign last = IDX_W'(n_used - COUNT_W'(2));

    // The input side is ready only in idle; the output register decouples
    // the result from the next item.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_i        <= n_i;
        r_left     <= n_left;
        r_right    <= n_right;
        r_lt       <= n_lt;
        r_dq_mag   <= n_dq_mag;
        r_dq_neg   <= n_dq_neg;
        r_dx_mag   <= n_dx_mag;
        r_neg      <= n_neg;
        r_mcand    <= n_mcand;
        r_acc      <= n_acc;
        r_lo       <= n_lo;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    // ------------------------------------------------------------------
    // Next state and datapath control. Every arithmetic step, from the
    // interval search through the final sum, goes through the one adder.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_i         = r_i;
        n_left      = r_left;
        n_right     = r_right;
        n_lt        = r_lt;
        n_dq_mag    = r_dq_mag;
        n_dq_neg    = r_dq_neg;
        n_dx_mag    = r_dx_mag;
        n_neg       = r_neg;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_status    = r_status;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        tbl_wr      = '{en: 1'b0, idx: i_in_data.point_index,
                        entry: '{x: i_in_data.point_x, y: i_in_data.point_y}};
        rd_idx      = '0;
        alu_req     = '{a: '0, b: '0, sub: 1'b0};
        gt          = 1'b0;
        yr_clamp    = r_right.y;
        trial       = {r_acc[31:0], r_lo[31]};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.operation == OP_WRITE) begin
                        tbl_wr.en = 1'b1;
                    end else begin
                        n_x     = i_in_data.query_x;
                        rd_idx  = last;
                        n_state = S_TOP;
                    end
                end
            end

            // At or beyond the second-to-last breakpoint the last interval
            // is taken outright; otherwise the scan starts at the first.
            S_TOP: begin
                alu_req = '{a: sext(r_x), b: sext(rd_entry.x), sub: 1'b1};
                if (!alu_res.neg) begin
                    n_left  = rd_entry;
                    n_i     = last;
                    rd_idx  = last + IDX_W'(1);
                    n_state = S_SCAN;
                end else begin
                    rd_idx  = '0;
                    n_state = S_LEFT0;
                end
            end

            S_LEFT0: begin
                n_left  = rd_entry;
                n_i     = '0;
                rd_idx  = IDX_W'(1);
                n_state = S_SCAN;
            end

            // The read data holds the right end of interval r_i. The scan
            // stops at the first right end at or above x, or at the last
            // interval.
            S_SCAN: begin
                alu_req = '{a: sext(r_x), b: sext(rd_entry.x), sub: 1'b1};
                if (r_i == last || alu_res.neg || alu_res.zero) begin
                    n_right = rd_entry;
                    n_state = S_CLL;
                end else begin
                    n_left  = rd_entry;
                    n_i     = r_i + IDX_W'(1);
                    rd_idx  = r_i + IDX_W'(2);
                end
            end

            S_CLL: begin
                alu_req  = '{a: sext(r_x), b: sext(r_left.x), sub: 1'b1};
                n_dq_mag = mag(alu_res.sum);
                n_dq_neg = alu_res.neg;
                n_lt     = alu_res.neg;
                n_state  = S_CLR;
            end

            // Without extrapolation a query left of the interval takes the
            // left ordinate and one right of it the right ordinate.
            S_CLR: begin
                alu_req = '{a: sext(r_x), b: sext(r_right.x), sub: 1'b1};
                gt      = !alu_res.neg && !alu_res.zero;
                if (!r_extrap && r_lt) begin
                    yr_clamp = r_left.y;
                end
                n_right.y = yr_clamp;
                if (!r_extrap && gt) begin
                    n_left.y = yr_clamp;
                end
                n_state = S_DX;
            end

            S_DX: begin
                alu_req = '{a: sext(r_right.x), b: sext(r_left.x), sub: 1'b1};
                if (alu_res.zero) begin
                    n_res    = r_left.y;
                    n_status = STATUS_EQUAL;
                    n_state  = S_DONE;
                end else begin
                    n_dx_mag = mag(alu_res.sum);
                    n_neg    = r_dq_neg ^ alu_res.neg;
                    n_state  = S_DY;
                end
            end

            S_DY: begin
                alu_req = '{a: sext(r_right.y), b: sext(r_left.y), sub: 1'b1};
                n_mcand = mag(alu_res.sum);
                n_neg   = r_neg ^ alu_res.neg;
                n_acc   = '0;
                n_lo    = r_dq_mag;
                n_cnt   = 6'd32;
                n_state = S_MUL;
            end

            // Shift-add multiply: {r_acc, r_lo} ends as the 66-bit product.
            S_MUL: begin
                alu_req = '{a: {1'b0, r_acc},
                            b: r_lo[0] ? {1'b0, r_mcand} : '0,
                            sub: 1'b0};
                n_acc = alu_res.sum[ALU_W-1:1];
                n_lo  = {alu_res.sum[0], r_lo[MAG_W-1:1]};
                if (r_cnt == '0) begin
                    n_state = S_DIVCHK;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end

            // If the upper product half reaches the divisor the quotient is
            // at least 2^32 and the sum leaves the 32-bit range for sure.
            S_DIVCHK: begin
                alu_req = '{a: {1'b0, r_acc[31:0], r_lo[32]},
                            b: {1'b0, r_dx_mag}, sub: 1'b1};
                if (!alu_res.neg) begin
                    n_res    = r_neg ? SAT_MIN : SAT_MAX;
                    n_status = STATUS_SAT;
                    n_state  = S_DONE;
                end else begin
                    n_acc   = {r_acc[31:0], r_lo[32]};
                    n_lo    = {1'b0, r_lo[31:0]};
                    n_cnt   = 6'd31;
                    n_state = S_DIV;
                end
            end

            // Restoring division, one quotient bit per cycle into r_lo.
            S_DIV: begin
                alu_req = '{a: {1'b0, trial}, b: {1'b0, r_dx_mag}, sub: 1'b1};
                n_acc   = alu_res.neg ? trial : alu_res.sum[MAG_W-1:0];
                n_lo    = {1'b0, r_lo[30:0], !alu_res.neg};
                if (r_cnt == '0) begin
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end

            S_ADD: begin
                alu_req = '{a: sext(r_left.y), b: {2'b00, r_lo[31:0]}, sub: r_neg};
                if (!alu_res.sum[ALU_W-1] && alu_res.sum[ALU_W-2:31] != '0) begin
                    n_res    = SAT_MAX;
                    n_status = STATUS_SAT;
                end else if (alu_res.sum[ALU_W-1] && alu_res.sum[ALU_W-2:31] != '1) begin
                    n_res    = SAT_MIN;
                    n_status = STATUS_SAT;
                end else begin
                    n_res    = alu_res.sum[31:0];
                    n_status = STATUS_OK;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{interp_value: r_res, status: r_status};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/plti_table.sv */
// ---------------------------------------------------------------------------
// Breakpoint table
// Sixteen (x, y) pairs with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plti_table (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  plti_pkg::t_tbl_wr                   i_wr,
    input  wire  [plti_pkg::IDX_W-1:0]          i_rd_idx,
    output plti_pkg::t_entry                    o_rd_entry
);
    import plti_pkg::*;

    t_entry                r_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_valid;
    t_entry                r_rd;

    // An entry never written since reset reads as its power-up value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        r_rd <= r_valid[i_rd_idx] ? r_mem[i_rd_idx] : reset_entry(i_rd_idx);
    end

    assign o_rd_entry = r_rd;

endmodule

`default_nettype wire

/* sv/plti_alu.sv */
// ---------------------------------------------------------------------------
// Shared adder
// One 34-bit add/subtract with sign and zero flags, used by every step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plti_alu (
    input  plti_pkg::t_alu_req i_req,
    output plti_pkg::t_alu_res o_res
);
    import plti_pkg::*;

    logic [ALU_W-1:0] sum;

    always_comb begin
        if (i_req.sub) begin
            sum = i_req.a - i_req.b;
        end else begin
            sum = i_req.a + i_req.b;
        end
    end

    assign o_res.sum  = sum;
    assign o_res.neg  = sum[ALU_W-1];
    assign o_res.zero = (sum == '0);

endmodule

`default_nettype wire

/* sv/plti_checker.sv */
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator port checker
// Watches the top-level ports; bound to every instance of the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_table_interp_macros.svh"

module plti_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 psel,
    input wire                 penable,
    input wire                 pwrite,
    input wire [2:0]           paddr,
    input wire [31:0]          pwdata,
    input wire [31:0]          prdata,
    input wire                 pready,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input plti_pkg::t_in_item  i_in_data,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input plti_pkg::t_out_item o_out_data
);
    import plti_pkg::*;

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // A result held by the receiver stays put.
    `PLTI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // A query keeps the block busy in the following cycle.
    `PLTI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_take && i_in_data.operation == OP_QUERY, o_in_stall)

    // A table write never produces a result.
    `PLTI_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, in_take && i_in_data.operation == OP_WRITE && !o_out_valid, !o_out_valid)

    // Saturation is flagged only on a bound of the 32-bit range.
    `PLTI_ASSERT_IMP(a_sat_bound, i_clk, i_rst_n, o_out_valid && o_out_data.status == STATUS_SAT, o_out_data.interp_value == SAT_MAX || o_out_data.interp_value == SAT_MIN)

    // Only the three defined status codes appear.
    `PLTI_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_out_data.status == STATUS_OK || o_out_data.status == STATUS_EQUAL || o_out_data.status == STATUS_SAT)

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (.*);

`default_nettype wire

/* sim/piecewise_linear_table_interp_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator testbench
// Drives write and query items through the valid/stall input channel, sets
// the point count and extrapolation mode over the APB port between phases,
// and checks every result item against its typed value or a self-contained
// predictor keeping its own copy of the breakpoint table. A short directed
// table comes first, then random phases built mostly on sorted tables.
// ---------------------------------------------------------------------------

module piecewise_linear_table_interp_tb;

    import plti_pkg::*;

    // Register indexes; each register sits at byte address 4 * index.
    typedef enum int {
        REG_POINT_COUNT = 0,
        REG_EXTRAPOLATE = 1
    } cfg_reg_e;

    typedef enum int {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    // One line of the directed stimulus. A row with a typed result carries
    // the value that can be read straight off the table; other query rows
    // are checked against the predictor.
    typedef struct {
        row_kind_e  kind;
        cfg_reg_e   cfg_sel;
        logic [4:0] cfg_value;
        t_in_item   item;
        bit         typed;
        t_out_item  want;
    } stim_row_t;

    localparam int ITEM_TARGET   = 1900;
    // Even with the longest sender gap and receiver stall on every item the
    // run stays far below this limit, so it leaves a wide margin.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Cycles waited after the queue drained, before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam logic [65:0] QUOT_CAP = 66'd1 << 40;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    // Block ports; every input starts at a known value.
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    in_item   = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;

    piecewise_linear_table_interp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // Predictor state: a private copy of the breakpoint table and registers.
    logic signed [31:0] shadow_x [16];
    logic signed [31:0] shadow_y [16];
    logic [4:0]         cfg_point_count;
    logic               cfg_extrapolate;
    longint             mach_units [15];
    longint             angle_units [15];

    // Results the block still owes, oldest first.
    t_out_item pending_results [$];

    int          err_count  = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    logic [31:0] stall_tick = '0;
    stim_row_t   directed_rows [$];

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Power-up table: Mach number and maximum deflection angle, given in
    // units of 1e-7 and rounded to nearest Q16.16.
    task automatic init_shadow();
        mach_units  = '{10500000, 11000000, 12000000, 13000000, 14000000,
                        16000000, 18000000, 20000000, 25000000, 30000000,
                        40000000, 50000000, 60000000, 80000000, 100000000};
        angle_units = '{97403, 264446, 688391, 1162752, 1645352,
                        2557175, 3348112, 4009638, 5200634, 5946937,
                        6767315, 7176386, 7407139, 7642938, 7754327};
        for (int k = 0; k < 16; k++) begin
            if (k < 15) begin
                shadow_x[k] = 32'((mach_units[k] * 65536 + 5000000) / 10000000);
                shadow_y[k] = 32'((angle_units[k] * 65536 + 5000000) / 10000000);
            end else begin
                shadow_x[k] = '0;
                shadow_y[k] = '0;
            end
        end
        cfg_point_count = 5'd15;
        cfg_extrapolate = 1'b0;
    endtask

    // The block clamps the point count into [2, 16].
    function automatic int points_in_use(input logic [4:0] cnt);
        if (cnt < 2)
            return 2;
        if (cnt > 16)
            return 16;
        return int'(cnt);
    endfunction

    // Interpolated ordinate for one query, from the shadow table.
    function automatic t_out_item interp_predict(input logic signed [31:0] qx);
        int          n_eff;
        int          seg;
        longint      xl, yl, xr, yr, dx, dy, dq, res;
        logic [65:0] mag_dy, mag_dq, mag_dx, quot;
        bit          neg;
        t_out_item   r;
        n_eff = points_in_use(cfg_point_count);
        // At or past the second-to-last breakpoint the last interval is used;
        // otherwise the first interval whose right end reaches the query.
        if (qx >= shadow_x[n_eff-2]) begin
            seg = n_eff - 2;
        end else begin
            seg = 0;
            while (seg < n_eff - 2 && qx > shadow_x[seg+1])
                seg++;
        end
        xl = shadow_x[seg];
        yl = shadow_y[seg];
        xr = shadow_x[seg+1];
        yr = shadow_y[seg+1];
        // Clamping to the interval's end values when extrapolation is off.
        if (!cfg_extrapolate) begin
            if (longint'(qx) < xl)
                yr = yl;
            if (longint'(qx) > xr)
                yl = yr;
        end
        dx = xr - xl;
        r.status = STATUS_OK;
        if (dx == 0) begin
            // Equal breakpoints: the (possibly clamped) left ordinate.
            res = yl;
            r.status = STATUS_EQUAL;
        end else begin
            dy = yr - yl;
            dq = longint'(qx) - xl;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            mag_dy = 66'((dy < 0) ? -dy : dy);
            mag_dq = 66'((dq < 0) ? -dq : dq);
            mag_dx = 66'((dx < 0) ? -dx : dx);
            // Quotient of magnitudes truncates toward zero and is capped.
            quot = (mag_dy * mag_dq) / mag_dx;
            if (quot > QUOT_CAP)
                quot = QUOT_CAP;
            res = neg ? yl - longint'(quot) : yl + longint'(quot);
            if (res > longint'(SAT_MAX)) begin
                res = longint'(SAT_MAX);
                r.status = STATUS_SAT;
            end else if (res < longint'(SAT_MIN)) begin
                res = longint'(SAT_MIN);
                r.status = STATUS_SAT;
            end
        end
        r.interp_value = res[31:0];
        return r;
    endfunction

    // Offers one item and returns at the edge where it is taken. The sender
    // works in bursts; between bursts valid drops for a random gap. Called
    // and returning at a rising edge.
    task automatic drive_item(input t_in_item it, input bit typed,
                              input t_out_item want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                              : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        // Stall is stable between edges, so the falling edge tells whether
        // the coming rising edge takes the item.
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        burst_left--;
        items_sent++;
        if (it.operation == OP_WRITE) begin
            shadow_x[it.point_index] = it.point_x;
            shadow_y[it.point_index] = it.point_y;
        end else begin
            pending_results.push_back(typed ? want : interp_predict(it.query_x));
        end
    endtask

    // Writes one register once the block is idle: no result owed and enough
    // cycles passed for any write item still inside to land.
    task automatic program_reg(input cfg_reg_e sel, input logic [4:0] value);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        // Setup phase, then access phase; the write lands when pready is seen.
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(sel));
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_POINT_COUNT)
            cfg_point_count = value;
        else
            cfg_extrapolate = value[0];
    endtask

    function automatic stim_row_t stim_query(input logic [31:0] qx, input bit typed,
                                             input logic [31:0] val,
                                             input logic [1:0] st);
        stim_row_t row;
        row = '{kind: ROW_ITEM, cfg_sel: REG_POINT_COUNT, cfg_value: '0,
                item: '0, typed: typed, want: '0};
        row.item.operation    = OP_QUERY;
        row.item.query_x      = qx;
        row.want.interp_value = val;
        row.want.status       = st;
        return row;
    endfunction

    function automatic stim_row_t stim_write(input logic [3:0] idx,
                                             input logic [31:0] px,
                                             input logic [31:0] py);
        stim_row_t row;
        row = '{kind: ROW_ITEM, cfg_sel: REG_POINT_COUNT, cfg_value: '0,
                item: '0, typed: 1'b0, want: '0};
        row.item.operation   = OP_WRITE;
        row.item.point_index = idx;
        row.item.point_x     = px;
        row.item.point_y     = py;
        row.item.query_x     = 32'hFFFF_FFFF;
        return row;
    endfunction

    function automatic stim_row_t stim_cfg(input cfg_reg_e sel, input logic [4:0] value);
        return '{kind: ROW_CFG, cfg_sel: sel, cfg_value: value,
                 item: '0, typed: 1'b0, want: '0};
    endfunction

    // A query aimed at the table in use: on a breakpoint, just beside one,
    // inside an interval, anywhere, or at the ends of the input range.
    function automatic t_in_item make_query();
        int       n_eff, k, kr, pick;
        longint   lo, hi, qx;
        t_in_item it;
        n_eff = points_in_use(cfg_point_count);
        k     = $urandom_range(0, n_eff - 1);
        kr    = (k < n_eff - 1) ? k + 1 : k;
        lo    = shadow_x[k];
        hi    = shadow_x[kr];
        pick  = $urandom_range(0, 9);
        case (pick)
            0, 1:    qx = lo;
            2, 3:    qx = lo + longint'($urandom_range(0, 64)) - 32;
            4, 5, 6: qx = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
            7, 8:    qx = longint'($urandom);
            default: qx = $urandom_range(0, 1) ? longint'(SAT_MIN) : longint'(SAT_MAX);
        endcase
        it.operation   = OP_QUERY;
        it.point_index = 4'($urandom);
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        it.query_x     = qx[31:0];
        return it;
    endfunction

    // Rewrites all sixteen entries with ascending x. Small steps sometimes
    // repeat an abscissa, which gives equal-breakpoint intervals.
    task automatic load_sorted_table();
        longint   x_acc, y_acc;
        int       step_kind;
        t_in_item it;
        x_acc     = -longint'($urandom_range(0, 32'h4000_0000));
        y_acc     = longint'($signed($urandom));
        step_kind = $urandom_range(0, 2);
        for (int k = 0; k < 16; k++) begin
            it.operation   = OP_WRITE;
            it.point_index = 4'(k);
            it.point_x     = x_acc[31:0];
            it.point_y     = y_acc[31:0];
            it.query_x     = $urandom;
            drive_item(it, 1'b0, '0);
            case (step_kind)
                0:       x_acc += $urandom_range(0, 300);
                1:       x_acc += $urandom_range(1, 32'h0100_0000);
                default: x_acc += $urandom_range(32'h0010_0000, 32'h0400_0000);
            endcase
            if ($urandom_range(0, 1))
                y_acc = longint'($signed($urandom));
            else
                y_acc = y_acc + $urandom_range(0, 2000) - 1000;
        end
    endtask

    // Receiver stall pattern: free-running, stalls now and then, stalls
    // mostly, and a fixed pulse train, taken in turn from the tick counter.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[10:9])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 37) < 20);
        endcase
    end

    // Result check. Outputs are sampled at the falling edge, where they hold
    // the values that the next rising edge will take.
    always @(negedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value %0d status %0d",
                                        o_out_data.interp_value, o_out_data.status));
            end else begin
                exp_item = pending_results.pop_front();
                if (o_out_data.interp_value !== exp_item.interp_value)
                    flag_mismatch($sformatf("interp_value got %0d expected %0d",
                                            o_out_data.interp_value,
                                            exp_item.interp_value));
                if (o_out_data.status !== exp_item.status)
                    flag_mismatch($sformatf("status got %0d expected %0d",
                                            o_out_data.status, exp_item.status));
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("piecewise_linear_table_interp_tb failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int n_pick;
        int waited;
        t_in_item it;

        init_shadow();

        // Directed part. After reset the table holds the Mach table with
        // 15 points in use and clamping on.
        directed_rows.push_back(stim_query(SAT_MIN, 1'b1, 32'sd638, STATUS_OK));
        directed_rows.push_back(stim_query(SAT_MAX, 1'b1, 32'sd50819, STATUS_OK));
        // A query on a breakpoint lands on that breakpoint's ordinate.
        directed_rows.push_back(stim_query(32'sd131072, 1'b1, 32'sd26278, STATUS_OK));
        directed_rows.push_back(stim_query(32'sd100000, 1'b0, '0, '0));
        directed_rows.push_back(stim_query(32'sd600000, 1'b0, '0, '0));
        // Linear extrapolation off both ends of the table.
        directed_rows.push_back(stim_cfg(REG_EXTRAPOLATE, 5'd1));
        directed_rows.push_back(stim_query(32'sd0, 1'b0, '0, '0));
        directed_rows.push_back(stim_query(SAT_MAX, 1'b0, '0, '0));
        // Count above the table size clamps to 16, pulling in the zero entry
        // and so an unsorted last interval.
        directed_rows.push_back(stim_cfg(REG_POINT_COUNT, 5'd31));
        directed_rows.push_back(stim_query(32'sd700000, 1'b0, '0, '0));
        directed_rows.push_back(stim_query(SAT_MAX, 1'b0, '0, '0));
        // Count zero clamps to two points. A steep first interval drives
        // the quotient into its cap and the sum past both bounds.
        directed_rows.push_back(stim_cfg(REG_POINT_COUNT, 5'd0));
        directed_rows.push_back(stim_write(4'd0, 32'sd0, 32'sd0));
        directed_rows.push_back(stim_write(4'd1, 32'sd1, SAT_MAX));
        directed_rows.push_back(stim_query(SAT_MAX, 1'b1, SAT_MAX, STATUS_SAT));
        directed_rows.push_back(stim_query(SAT_MIN, 1'b1, SAT_MIN, STATUS_SAT));
        // Equal breakpoints give the left ordinate, or the right one once
        // clamping moves it there.
        directed_rows.push_back(stim_write(4'd1, 32'sd0, 32'sd12345));
        directed_rows.push_back(stim_query(32'sd5, 1'b1, 32'sd0, STATUS_EQUAL));
        directed_rows.push_back(stim_cfg(REG_EXTRAPOLATE, 5'd0));
        directed_rows.push_back(stim_query(32'sd5, 1'b1, 32'sd12345, STATUS_EQUAL));
        // Extreme values at the top of the table, all sixteen points in use.
        directed_rows.push_back(stim_write(4'd15, SAT_MIN, SAT_MIN));
        directed_rows.push_back(stim_write(4'd14, SAT_MAX, SAT_MAX));
        directed_rows.push_back(stim_cfg(REG_POINT_COUNT, 5'd16));
        directed_rows.push_back(stim_query(SAT_MAX, 1'b0, '0, '0));
        directed_rows.push_back(stim_query(SAT_MIN, 1'b0, '0, '0));
        directed_rows.push_back(stim_query(32'sd17, 1'b0, '0, '0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                program_reg(directed_rows[r].cfg_sel, directed_rows[r].cfg_value);
            else
                drive_item(directed_rows[r].item, directed_rows[r].typed,
                           directed_rows[r].want);
        end

        // Random phases. Each one picks a point count (the clamped values
        // included) and a mode, usually loads a fresh sorted table, and then
        // sends mostly queries with some stray writes mixed in.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase % 9)
                0:       n_pick = 2;
                1:       n_pick = 16;
                2:       n_pick = 15;
                3:       n_pick = 3;
                4:       n_pick = 0;
                5:       n_pick = 31;
                6:       n_pick = 1;
                7:       n_pick = 17;
                default: n_pick = $urandom_range(0, 31);
            endcase
            program_reg(REG_POINT_COUNT, 5'(n_pick));
            program_reg(REG_EXTRAPOLATE, 5'(phase % 2));
            if ($urandom_range(0, 3) != 0)
                load_sorted_table();
            repeat (100) begin
                if ($urandom_range(0, 99) < 88) begin
                    it = make_query();
                end else begin
                    it.operation   = OP_WRITE;
                    it.point_index = 4'($urandom);
                    it.point_x     = $urandom;
                    it.point_y     = $urandom;
                    it.query_x     = $urandom;
                end
                drive_item(it, 1'b0, '0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived",
                                    pending_results.size()));

        if (err_count == 0) begin
            $display("piecewise_linear_table_interp_tb passed");
        end else begin
            $display("piecewise_linear_table_interp_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/plti_pkg.sv
sv/plti_table.sv
sv/plti_alu.sv
sv/piecewise_linear_table_interp.sv
sv/plti_checker.sv
sim/piecewise_linear_table_interp_tb.sv
